// File: rtl/nbm_pkg.sv
// ----------------------------------------------------------------------------
// nbm_pkg
// Types and constants for the bank mapper with the CPU cycle IRQ counter.
// ----------------------------------------------------------------------------
package nbm_pkg;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_PRG   = 2'd2;
    localparam logic [1:0] KIND_CHR   = 2'd3;

    // register write map
    localparam logic [15:0] ADDR_PRG0     = 16'h8000;
    localparam logic [15:0] ADDR_PRG1     = 16'hA000;
    localparam logic [15:0] ADDR_PRG2     = 16'hC000;
    localparam logic [15:0] ADDR_MIRROR   = 16'h9001;
    localparam logic [15:0] ADDR_IRQ_EN   = 16'h9003;
    localparam logic [15:0] ADDR_IRQ_LOAD = 16'h9004;
    localparam logic [15:0] ADDR_RELOAD_H = 16'h9005;
    localparam logic [15:0] ADDR_RELOAD_L = 16'h9006;
    localparam logic [15:0] ADDR_CHR_LO   = 16'hB000;
    localparam logic [15:0] ADDR_CHR_HI   = 16'hB007;

    localparam int          DATA_FLAG_BIT = 7;
    localparam logic [1:0]  PRG_FIXED_SLOT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_MASK = 2'd0;
    localparam logic [1:0] CFG_CHR_MASK = 2'd1;
    localparam logic [1:0] CFG_MIRROR   = 2'd2;

    localparam logic [7:0] PRG_MASK_RST = 8'd15;
    localparam logic [7:0] CHR_MASK_RST = 8'd255;
    localparam logic [7:0] PRG0_RST     = 8'h00;
    localparam logic [7:0] PRG1_RST     = 8'h01;
    localparam logic [7:0] PRG2_RST     = 8'hFE;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_beat;

    typedef struct packed {
        logic       irq_line;
        logic       horizontal_mirroring;
        logic [7:0] page;
    } t_out_beat;

    // configuration as seen by the mapper core
    typedef struct packed {
        logic [7:0] prg_mask;
        logic [7:0] chr_mask;
        logic       mirror_wr;
        logic       mirror_val;
    } t_cfg;

    typedef struct packed {
        logic irq_enable;
        logic irq_flag;
    } t_status;

endpackage

// File: rtl/nbm_core.sv
// ----------------------------------------------------------------------------
// nbm_core
// Mapper state: bank registers, mirroring and the IRQ down counter. Gives the
// result of the current beat combinationally and commits the state on fire.
// ----------------------------------------------------------------------------
module nbm_core
    import nbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_beat  i_beat,
    input  t_cfg      i_cfg,
    output t_out_beat o_result,
    output t_status   o_status
);

    logic [7:0]  r_prg_bank [3];
    logic [7:0]  r_chr_bank [8];
    logic        r_mirror;
    logic        r_irq_en;
    logic [15:0] r_irq_cnt;
    logic [15:0] r_irq_reload;
    logic        r_irq_flag;

    logic        n_mirror;
    logic        n_irq_en;
    logic [15:0] n_irq_cnt;
    logic [15:0] n_irq_reload;
    logic        n_irq_flag;
    logic [7:0]  page;
    logic [15:0] cnt_dec;
    logic [1:0]  prg_slot;
    logic [2:0]  chr_slot;
    logic        wr_chr;
    logic [1:0]  wr_prg_idx;
    logic        wr_prg;

    assign cnt_dec  = r_irq_cnt - 16'd1;
    assign prg_slot = i_beat.address[14:13];
    assign chr_slot = i_beat.address[12:10];

    always_comb begin
        n_mirror     = r_mirror;
        n_irq_en     = r_irq_en;
        n_irq_cnt    = r_irq_cnt;
        n_irq_reload = r_irq_reload;
        n_irq_flag   = r_irq_flag;
        page         = 8'd0;
        wr_chr       = 1'b0;
        wr_prg       = 1'b0;
        wr_prg_idx   = 2'd0;
        case (i_beat.kind)
            KIND_WRITE: begin
                case (i_beat.address) inside
                    [ADDR_CHR_LO:ADDR_CHR_HI]: wr_chr = 1'b1;
                    ADDR_PRG0: begin
                        wr_prg     = 1'b1;
                        wr_prg_idx = 2'd0;
                    end
                    ADDR_PRG1: begin
                        wr_prg     = 1'b1;
                        wr_prg_idx = 2'd1;
                    end
                    ADDR_PRG2: begin
                        wr_prg     = 1'b1;
                        wr_prg_idx = 2'd2;
                    end
                    ADDR_MIRROR: n_mirror = i_beat.data[DATA_FLAG_BIT];
                    ADDR_IRQ_EN: begin
                        n_irq_en   = i_beat.data[DATA_FLAG_BIT];
                        n_irq_flag = 1'b0;
                    end
                    ADDR_IRQ_LOAD: begin
                        n_irq_cnt  = r_irq_reload;
                        n_irq_flag = 1'b0;
                    end
                    ADDR_RELOAD_H: n_irq_reload = {i_beat.data, r_irq_reload[7:0]};
                    ADDR_RELOAD_L: n_irq_reload = {r_irq_reload[15:8], i_beat.data};
                    default: ;
                endcase
            end
            KIND_TICK: begin
                if (r_irq_en) begin
                    n_irq_cnt = cnt_dec;
                    if (cnt_dec == 16'd0) begin
                        n_irq_en   = 1'b0;
                        n_irq_flag = 1'b1;
                    end
                end
            end
            KIND_PRG: begin
                // top slot is hardwired to the last page
                if (prg_slot == PRG_FIXED_SLOT) begin
                    page = i_cfg.prg_mask;
                end else begin
                    page = r_prg_bank[prg_slot] & i_cfg.prg_mask;
                end
            end
            default: page = r_chr_bank[chr_slot] & i_cfg.chr_mask;
        endcase
    end

    assign o_result.irq_line             = n_irq_flag;
    assign o_result.horizontal_mirroring = n_mirror;
    assign o_result.page                 = page;
    assign o_status.irq_enable           = r_irq_en;
    assign o_status.irq_flag             = r_irq_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank[0] <= PRG0_RST;
            r_prg_bank[1] <= PRG1_RST;
            r_prg_bank[2] <= PRG2_RST;
            for (int i = 0; i < 8; i++) begin
                r_chr_bank[i] <= 8'd0;
            end
            r_mirror     <= 1'b0;
            r_irq_en     <= 1'b0;
            r_irq_cnt    <= 16'd0;
            r_irq_reload <= 16'd0;
            r_irq_flag   <= 1'b0;
        end else begin
            if (i_fire) begin
                if (wr_prg) begin
                    r_prg_bank[wr_prg_idx] <= i_beat.data;
                end
                if (wr_chr) begin
                    r_chr_bank[i_beat.address[2:0]] <= i_beat.data;
                end
                r_irq_en     <= n_irq_en;
                r_irq_cnt    <= n_irq_cnt;
                r_irq_reload <= n_irq_reload;
                r_irq_flag   <= n_irq_flag;
            end
            // strap reload of mirroring wins over a bus write
            if (i_cfg.mirror_wr) begin
                r_mirror <= i_cfg.mirror_val;
            end else if (i_fire) begin
                r_mirror <= n_mirror;
            end
        end
    end

endmodule

// File: rtl/nes_bank_mapper_cycle_irq_top.sv
// ----------------------------------------------------------------------------
// nes_bank_mapper_cycle_irq_top
// Bank mapper with CPU cycle IRQ: bus writes, ticks and bank lookups in,
// one result beat per input beat out.
// ----------------------------------------------------------------------------
// Results go to the output register, or to the skid entry under an output
// stall. Throughput: one beat per cycle unless the skid entry is full; the
// state update is a single pass of logic into the mapper registers, and a
// two-entry output buffer keeps input open while one result waits.
// Reset: synchronous, active low; config returns to defaults, banks and IRQ
// state to their power-up values, output buffer empties.
module nes_bank_mapper_cycle_irq_top
    import nbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat,
    input  logic      i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wr_data
);

    logic [7:0] r_prg_mask;
    logic [7:0] r_chr_mask;

    logic       r_out_valid;
    t_out_beat  r_out_beat;
    logic       r_skid_valid;
    t_out_beat  r_skid_beat;

    logic       in_fire;
    logic       out_take;
    t_cfg       cfg;
    t_out_beat  result;
    t_status    status;

    assign o_in_stall = r_skid_valid;
    assign in_fire    = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    assign cfg.prg_mask   = r_prg_mask;
    assign cfg.chr_mask   = r_chr_mask;
    assign cfg.mirror_wr  = i_cfg_wr_en && (i_cfg_index == CFG_MIRROR);
    assign cfg.mirror_val = i_cfg_wr_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask    <= PRG_MASK_RST;
            r_chr_mask    <= CHR_MASK_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PRG_MASK: r_prg_mask    <= i_cfg_wr_data;
                CFG_CHR_MASK: r_chr_mask    <= i_cfg_wr_data;
                // mirroring strap loads the core's mirroring register directly
                CFG_MIRROR: ;
                default: ;
            endcase
        end
    end

    nbm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_beat   (i_in_beat),
        .i_cfg    (cfg),
        .o_result (result),
        .o_status (status)
    );

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (!r_out_valid || out_take) begin
                r_out_beat <= result;
            end else begin
                r_skid_beat <= result;
            end
        end else if (out_take && r_skid_valid) begin
            r_out_beat <= r_skid_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("beat taken under output stall was not parked");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !in_fire && !r_skid_valid) |=> !r_out_valid)
        else $error("output stayed valid after last beat was taken");

    a_irq_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.irq_enable && status.irq_flag))
        else $error("IRQ counter enabled while IRQ line raised");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bank mapper with the CPU cycle IRQ counter.
// A driver offers bus beats from a queue and a monitor checks every result beat
// against an in-bench mapper model. Six phases step through several mask and
// mirroring settings and several sender and receiver idling mixes. Random
// beats include armed countdown runs so that the IRQ actually fires.
// ----------------------------------------------------------------------------
module tb;
    import nbm_pkg::*;

    localparam int HOLD_LEN   = 300;
    localparam int RAND_BEATS = 220;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_beat     = '0;
    logic       o_out_valid;
    logic       i_out_stall   = 1'b0;
    t_out_beat  o_out_beat;
    logic       i_cfg_wr_en   = 1'b0;
    logic [1:0] i_cfg_index   = '0;
    logic [7:0] i_cfg_wr_data = '0;

    nes_bank_mapper_cycle_irq_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_beat     (i_in_beat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_beat    (o_out_beat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // mapper model state
    logic [7:0]  m_prg_mask;
    logic [7:0]  m_chr_mask;
    logic [7:0]  m_prg_bank [3];
    logic [7:0]  m_chr_bank [8];
    logic        m_mirror_h;
    logic        m_irq_on;
    logic [15:0] m_irq_cnt;
    logic [15:0] m_irq_reload;
    logic        m_irq_pend;

    t_in_beat  bus_items [$];
    t_out_beat want_results [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int beats_in      = 0;
    int results_seen  = 0;
    int irq_fires     = 0;
    int cfg_writes    = 0;
    int mism_cnt      = 0;

    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    t_out_beat got_b;
    t_out_beat exp_b;

    function automatic t_out_beat mapper_step(input t_in_beat b);
        t_out_beat r;
        logic [1:0] slot;
        r = '0;
        case (b.kind)
            KIND_WRITE: begin
                if (b.address >= ADDR_CHR_LO && b.address <= ADDR_CHR_HI) begin
                    m_chr_bank[b.address[2:0]] = b.data;
                end else begin
                    case (b.address)
                        ADDR_PRG0:     m_prg_bank[0] = b.data;
                        ADDR_PRG1:     m_prg_bank[1] = b.data;
                        ADDR_PRG2:     m_prg_bank[2] = b.data;
                        ADDR_MIRROR:   m_mirror_h = b.data[DATA_FLAG_BIT];
                        ADDR_IRQ_EN: begin
                            m_irq_on   = b.data[DATA_FLAG_BIT];
                            m_irq_pend = 1'b0;
                        end
                        ADDR_IRQ_LOAD: begin
                            m_irq_cnt  = m_irq_reload;
                            m_irq_pend = 1'b0;
                        end
                        ADDR_RELOAD_H: m_irq_reload[15:8] = b.data;
                        ADDR_RELOAD_L: m_irq_reload[7:0]  = b.data;
                        default: ;
                    endcase
                end
            end
            KIND_TICK: begin
                if (m_irq_on) begin
                    m_irq_cnt = m_irq_cnt - 16'd1;
                    if (m_irq_cnt == 16'd0) begin
                        m_irq_on   = 1'b0;
                        m_irq_pend = 1'b1;
                        irq_fires++;
                    end
                end
            end
            KIND_PRG: begin
                slot = b.address[14:13];
                // top slot is hardwired to the last page
                if (slot == PRG_FIXED_SLOT) r.page = m_prg_mask;
                else                        r.page = m_prg_bank[slot] & m_prg_mask;
            end
            default: r.page = m_chr_bank[b.address[12:10]] & m_chr_mask;
        endcase
        r.irq_line             = m_irq_pend;
        r.horizontal_mirroring = m_mirror_h;
        return r;
    endfunction

    function automatic t_in_beat mk(input logic [1:0] k, input logic [15:0] a,
                                    input logic [7:0] d);
        t_in_beat b;
        b.kind    = k;
        b.address = a;
        b.data    = d;
        return b;
    endfunction

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        int sel;
        b.data    = 8'($urandom);
        b.address = 16'($urandom);
        sel = $urandom_range(99);
        if (sel < 30)      b.kind = KIND_TICK;
        else if (sel < 45) b.kind = KIND_PRG;
        else if (sel < 60) b.kind = KIND_CHR;
        else begin
            b.kind = KIND_WRITE;
            case ($urandom_range(12))
                0:  b.address = ADDR_PRG0;
                1:  b.address = ADDR_PRG1;
                2:  b.address = ADDR_PRG2;
                3:  b.address = ADDR_MIRROR;
                4:  b.address = ADDR_IRQ_EN;
                5:  b.address = ADDR_IRQ_LOAD;
                6: begin
                    b.address = ADDR_RELOAD_H;
                    // keep most reload values short enough to count out
                    if ($urandom_range(3) != 0) b.data = 8'd0;
                end
                7:  b.address = ADDR_RELOAD_L;
                8, 9: b.address = ADDR_CHR_LO | 16'($urandom_range(7));
                // near misses around the IRQ block and past the pattern banks
                10: b.address = ADDR_MIRROR - 16'd1 + 16'($urandom_range(7));
                11: b.address = ADDR_CHR_HI + 16'($urandom_range(1, 8));
                default: ;
            endcase
        end
        return b;
    endfunction

    // driver; also applies accepted beats and config writes to the model
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_PRG_MASK: m_prg_mask = i_cfg_wr_data;
                    CFG_CHR_MASK: m_chr_mask = i_cfg_wr_data;
                    CFG_MIRROR:   m_mirror_h = i_cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                want_results.push_back(mapper_step(i_in_beat));
                beats_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (bus_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_beat  <= bus_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started by a toggle on hold_req
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_left <= HOLD_LEN;
            hold_seen <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_b = o_out_beat;
                results_seen++;
                if (want_results.size() == 0) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("unexpected result beat irq=%0b mirror_h=%0b page=%0d",
                                 got_b.irq_line, got_b.horizontal_mirroring, got_b.page);
                end else begin
                    exp_b = want_results.pop_front();
                    if (got_b.irq_line !== exp_b.irq_line
                        || got_b.horizontal_mirroring !== exp_b.horizontal_mirroring
                        || got_b.page !== exp_b.page) begin
                        mism_cnt++;
                        if (mism_cnt <= 10) begin
                            $display("mismatch %0d: exp irq=%0b mirror_h=%0b page=%0d",
                                     results_seen, exp_b.irq_line,
                                     exp_b.horizontal_mirroring, exp_b.page);
                            $display("    got irq=%0b mirror_h=%0b page=%0d",
                                     got_b.irq_line, got_b.horizontal_mirroring,
                                     got_b.page);
                        end
                    end
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < sink_idle_pct);
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_drained();
        while (bus_items.size() != 0 || i_in_valid || want_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic push_directed();
        bus_items.push_back(mk(KIND_PRG, 16'h8000, 8'hFF));
        bus_items.push_back(mk(KIND_PRG, 16'hA000, 8'h00));
        bus_items.push_back(mk(KIND_PRG, 16'hC000, 8'h00));
        bus_items.push_back(mk(KIND_PRG, 16'hE000, 8'h00));
        // below 0x8000 the slot bits still select
        bus_items.push_back(mk(KIND_PRG, 16'h6000, 8'h00));
        bus_items.push_back(mk(KIND_PRG, 16'h2000, 8'h00));
        bus_items.push_back(mk(KIND_CHR, 16'hFC00, 8'hFF));
        bus_items.push_back(mk(KIND_WRITE, ADDR_PRG0, 8'hFF));
        bus_items.push_back(mk(KIND_WRITE, ADDR_PRG1, 8'h00));
        bus_items.push_back(mk(KIND_WRITE, ADDR_PRG2, 8'h80));
        bus_items.push_back(mk(KIND_WRITE, ADDR_CHR_HI, 8'hFF));
        bus_items.push_back(mk(KIND_WRITE, ADDR_CHR_HI + 16'd1, 8'h55));
        bus_items.push_back(mk(KIND_WRITE, 16'hFFFF, 8'hFF));
        bus_items.push_back(mk(KIND_CHR, 16'h1C00, 8'h00));
        bus_items.push_back(mk(KIND_PRG, 16'h0000, 8'h00));
        bus_items.push_back(mk(KIND_WRITE, ADDR_MIRROR, 8'h80));
        bus_items.push_back(mk(KIND_WRITE, ADDR_MIRROR, 8'h7F));
        bus_items.push_back(mk(KIND_TICK, 16'h0000, 8'h00));
        // short countdown that fires on the second tick
        bus_items.push_back(mk(KIND_WRITE, ADDR_RELOAD_H, 8'h00));
        bus_items.push_back(mk(KIND_WRITE, ADDR_RELOAD_L, 8'h02));
        bus_items.push_back(mk(KIND_WRITE, ADDR_IRQ_LOAD, 8'h00));
        bus_items.push_back(mk(KIND_WRITE, ADDR_IRQ_EN, 8'h80));
        repeat (3) bus_items.push_back(mk(KIND_TICK, 16'hFFFF, 8'hFF));
        bus_items.push_back(mk(KIND_WRITE, ADDR_IRQ_EN, 8'h00));
        // zero count wraps instead of firing
        bus_items.push_back(mk(KIND_WRITE, ADDR_RELOAD_L, 8'h00));
        bus_items.push_back(mk(KIND_WRITE, ADDR_IRQ_LOAD, 8'h00));
        bus_items.push_back(mk(KIND_WRITE, ADDR_IRQ_EN, 8'hFF));
        bus_items.push_back(mk(KIND_TICK, 16'h0000, 8'h00));
        bus_items.push_back(mk(KIND_WRITE, ADDR_IRQ_EN, 8'h00));
    endtask

    task automatic push_random(input int count);
        int n;
        int lo;
        n = 0;
        while (n < count) begin
            if ($urandom_range(9) == 0) begin
                // armed countdown: reload, load, enable, then mostly ticks
                lo = $urandom_range(1, 48);
                bus_items.push_back(mk(KIND_WRITE, ADDR_RELOAD_H,
                    ($urandom_range(7) == 0) ? 8'($urandom) : 8'd0));
                bus_items.push_back(mk(KIND_WRITE, ADDR_RELOAD_L, 8'(lo)));
                bus_items.push_back(mk(KIND_WRITE, ADDR_IRQ_LOAD, 8'($urandom)));
                bus_items.push_back(mk(KIND_WRITE, ADDR_IRQ_EN,
                    ($urandom_range(5) == 0) ? 8'($urandom) : (8'($urandom) | 8'h80)));
                n += 4;
                repeat (lo + $urandom_range(6)) begin
                    if ($urandom_range(4) == 0)
                        bus_items.push_back(mk($urandom_range(1) ? KIND_PRG : KIND_CHR,
                                               16'($urandom), 8'($urandom)));
                    else
                        bus_items.push_back(mk(KIND_TICK, 16'($urandom), 8'($urandom)));
                    n++;
                end
            end else begin
                bus_items.push_back(rand_beat());
                n++;
            end
        end
    endtask

    initial begin
        #400000;
        $display("nes_bank_mapper_cycle_irq_top verification failed");
        $finish;
    end

    initial begin
        int ph;
        logic [7:0] prg_m [6];
        logic [7:0] chr_m [6];
        logic       mir   [6];
        int         s_pct [6];
        int         r_pct [6];

        prg_m = '{8'd15, 8'd255, 8'd0, 8'd7,  8'h5A, 8'($urandom)};
        chr_m = '{8'd255, 8'd255, 8'd0, 8'd31, 8'hA5, 8'($urandom)};
        mir   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom)};
        s_pct = '{23, 23, 63, 63, 0, 0};
        r_pct = '{63, 63, 23, 23, 0, 0};

        m_prg_mask    = PRG_MASK_RST;
        m_chr_mask    = CHR_MASK_RST;
        m_prg_bank[0] = PRG0_RST;
        m_prg_bank[1] = PRG1_RST;
        m_prg_bank[2] = PRG2_RST;
        foreach (m_chr_bank[i]) m_chr_bank[i] = 8'd0;
        m_mirror_h    = 1'b0;
        m_irq_on      = 1'b0;
        m_irq_cnt     = 16'd0;
        m_irq_reload  = 16'd0;
        m_irq_pend    = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            @(posedge i_clk);
            src_idle_pct  <= s_pct[ph];
            sink_idle_pct <= r_pct[ph];
            // first phase runs on the reset defaults
            if (ph > 0) begin
                cfg_write(CFG_PRG_MASK, prg_m[ph]);
                cfg_write(CFG_CHR_MASK, chr_m[ph]);
                cfg_write(CFG_MIRROR, {7'd0, mir[ph]});
            end
            @(posedge i_clk);
            hold_req <= ~hold_req;
            if (ph == 0) push_directed();
            push_random(RAND_BEATS);
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        mism_cnt += want_results.size();

        $display("run: %0d bus beats in, %0d result beats checked, %0d config writes",
                 beats_in, results_seen, cfg_writes);
        $display("     %0d IRQ assertions over six mask/mirroring/idling phases",
                 irq_fires);
        if (mism_cnt == 0) begin
            $display("nes_bank_mapper_cycle_irq_top verification clean");
        end else begin
            $display("%0d mismatching result beats", mism_cnt);
            $display("nes_bank_mapper_cycle_irq_top verification failed");
        end
        $finish;
    end

endmodule

// File: nes_bank_mapper_cycle_irq_top.f
rtl/nbm_pkg.sv
rtl/nbm_core.sv
rtl/nes_bank_mapper_cycle_irq_top.sv
verif/tb.sv
